### design/mqttf_pkg.sv
// Package: shared types and constants for the MQTT publish/subscribe framer
package mqttf_pkg;

   // Request modes
   localparam logic [1:0] MODE_PUBLISH     = 2'd0;
   localparam logic [1:0] MODE_SUBSCRIBE   = 2'd1;
   localparam logic [1:0] MODE_UNSUBSCRIBE = 2'd2;
   localparam logic [1:0] MODE_CONTENT     = 2'd3;

   // Result status codes
   localparam logic [1:0] STATUS_OK          = 2'd0;
   localparam logic [1:0] STATUS_EMPTY_TOPIC = 2'd1;
   localparam logic [1:0] STATUS_TOO_LONG    = 2'd2;

   // Framer phases
   localparam logic [1:0] PHASE_IDLE    = 2'd0;
   localparam logic [1:0] PHASE_TOPIC   = 2'd1;
   localparam logic [1:0] PHASE_PAYLOAD = 2'd2;

   // Fixed header bytes
   localparam logic [3:0] HDR_PUBLISH_TYPE = 4'h3;
   localparam logic [7:0] HDR_SUBSCRIBE    = 8'h82;
   localparam logic [7:0] HDR_UNSUBSCRIBE  = 8'hA2;

   // Remaining-length overhead beyond the topic bytes
   localparam logic [4:0] BODY_PUB_FIXED  = 5'd2;
   localparam logic [4:0] BODY_PUB_IDENT  = 5'd2;
   localparam logic [4:0] BODY_SUB_FIXED  = 5'd5;
   localparam logic [4:0] BODY_UNSUB_FIXED = 5'd4;

   localparam int RUN_BYTES = 8;

   // One run of result bytes caused by one request
   typedef struct packed {
      logic [RUN_BYTES-1:0][7:0] data;
      logic [2:0]                last_idx;
      logic                      pend;
      logic [1:0]                status;
   } job_type;

endpackage

### design/mqtt_publish_subscribe_framer.sv
// Top level: MQTT 3.1.1 PUBLISH / SUBSCRIBE / UNSUBSCRIBE byte framer
//
// Requests arrive on the req_ channel (valid/ready). A start request (mode
// publish, subscribe or unsubscribe) produces the fixed header, remaining
// length, packet identifier (subscribe/unsubscribe) and topic length as a
// run of up to 8 response bytes. Content requests carry topic then payload
// bytes, passed through one response each, with the identifier or requested
// QoS byte appended after the last topic byte. rsp_run_end marks the last
// response of each request; rsp_packet_end marks the final packet byte.
// The first response byte passes through the run queue and then the output
// register before it is presented. Throughput: one request per cycle while
// runs are one byte long and rsp_ready stays high; a start request occupies
// the response side for its whole run, set by the one-byte-per-cycle output
// register.
// A QUEUE_DEPTH-entry run queue decouples the sides: req_ready drops only
// when it is full, so a stalled receiver backs up into the request side
// after QUEUE_DEPTH runs plus the byte in the output register.
// Reset clears the queue, returns to idle and sets the identifier to 1.
module mqtt_publish_subscribe_framer #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_mode,
   input  logic [15:0] req_topic_length,
   input  logic [27:0] req_payload_length,
   input  logic [1:0]  req_qos,
   input  logic        req_retained,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_packet_end,
   output logic        rsp_run_end,
   output logic [1:0]  rsp_status
);

   logic               q_full;
   logic               req_fire;
   logic               job_valid;
   mqttf_pkg::job_type job;
   logic               head_valid;
   mqttf_pkg::job_type head_job;
   logic               pop;

   assign req_ready = !q_full;
   assign req_fire  = req_valid && req_ready;

   mqttf_front u_front (
      .clock             (clock),
      .reset             (reset),
      .in_fire           (req_fire),
      .in_mode           (req_mode),
      .in_topic_length   (req_topic_length),
      .in_payload_length (req_payload_length),
      .in_qos            (req_qos),
      .in_retained       (req_retained),
      .in_data_byte      (req_data_byte),
      .job_valid         (job_valid),
      .job               (job)
   );

   mqttf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (job_valid),
      .push_job   (job),
      .pop        (pop),
      .full       (q_full),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   mqttf_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (head_valid),
      .head_job       (head_job),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_packet_end (rsp_packet_end),
      .rsp_run_end    (rsp_run_end),
      .rsp_status     (rsp_status)
   );

   // A rejection is a single response closing its run, never a packet end
   a_reject_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != mqttf_pkg::STATUS_OK) |-> rsp_run_end && !rsp_packet_end)
      else $error("rejection response not a lone run end");

   // The final packet byte always closes its request's run
   a_pend_run_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_packet_end |-> rsp_run_end)
      else $error("packet end without run end");

   // Reset empties the output register and the queue
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("state not cleared by reset");

endmodule

### design/mqttf_front.sv
// Front end: accepts requests, tracks packet state and builds byte runs
module mqttf_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_fire,
   input  logic [1:0]          in_mode,
   input  logic [15:0]         in_topic_length,
   input  logic [27:0]         in_payload_length,
   input  logic [1:0]          in_qos,
   input  logic                in_retained,
   input  logic [7:0]          in_data_byte,
   output logic                job_valid,
   output mqttf_pkg::job_type  job
);

   logic [15:0] packet_ident_ff, packet_ident_in;
   logic [1:0]  phase_ff, phase_in;
   logic [1:0]  kind_ff, kind_in;
   logic [1:0]  held_qos_ff, held_qos_in;
   logic [15:0] held_ident_ff, held_ident_in;
   logic [15:0] topic_left_ff, topic_left_in;
   logic [27:0] payload_left_ff, payload_left_in;

   logic [28:0]      pub_body;
   logic [27:0]      body_len;
   logic             too_long;
   logic [15:0]      ident_next;
   logic             take_ident;
   logic [7:0]       hdr;
   logic [3:0][7:0]  len_byte;
   logic [2:0]       nlen;
   logic [3:0][7:0]  tail_byte;
   logic [2:0]       ntail;
   logic [2:0]       idx;
   logic [3:0]       last_sum;

   // Compute the body length and the overlong check
   always_comb begin
      pub_body = 29'(mqttf_pkg::BODY_PUB_FIXED) + 29'(in_topic_length)
               + 29'(in_payload_length)
               + ((in_qos != 2'd0) ? 29'(mqttf_pkg::BODY_PUB_IDENT) : 29'd0);
      case (in_mode)
         mqttf_pkg::MODE_PUBLISH:   body_len = pub_body[27:0];
         mqttf_pkg::MODE_SUBSCRIBE:
            body_len = 28'(in_topic_length) + 28'(mqttf_pkg::BODY_SUB_FIXED);
         default:
            body_len = 28'(in_topic_length) + 28'(mqttf_pkg::BODY_UNSUB_FIXED);
      endcase
      too_long = (in_mode == mqttf_pkg::MODE_PUBLISH) && pub_body[28];
   end

   // Advance the identifier counter, skipping zero
   always_comb begin
      ident_next = packet_ident_ff + 16'd1;
      if (ident_next == 16'd0) begin
         ident_next = 16'd1;
      end
      take_ident = (in_mode != mqttf_pkg::MODE_PUBLISH) || (in_qos != 2'd0);
   end

   // Encode the fixed header and remaining length
   always_comb begin
      case (in_mode)
         mqttf_pkg::MODE_PUBLISH:
            hdr = {mqttf_pkg::HDR_PUBLISH_TYPE, 1'b0, in_qos, in_retained};
         mqttf_pkg::MODE_SUBSCRIBE: hdr = mqttf_pkg::HDR_SUBSCRIBE;
         default:                   hdr = mqttf_pkg::HDR_UNSUBSCRIBE;
      endcase
      len_byte[0] = {(body_len[27:7] != 21'd0), body_len[6:0]};
      len_byte[1] = {(body_len[27:14] != 14'd0), body_len[13:7]};
      len_byte[2] = {(body_len[27:21] != 7'd0), body_len[20:14]};
      len_byte[3] = {1'b0, body_len[27:21]};
      if (body_len[27:7] == 21'd0) begin
         nlen = 3'd1;
      end else if (body_len[27:14] == 14'd0) begin
         nlen = 3'd2;
      end else if (body_len[27:21] == 7'd0) begin
         nlen = 3'd3;
      end else begin
         nlen = 3'd4;
      end
      if (in_mode == mqttf_pkg::MODE_PUBLISH) begin
         tail_byte = {16'd0, in_topic_length[7:0], in_topic_length[15:8]};
         ntail     = 3'd2;
      end else begin
         tail_byte = {in_topic_length[7:0], in_topic_length[15:8],
                      packet_ident_ff[7:0], packet_ident_ff[15:8]};
         ntail     = 3'd4;
      end
      last_sum = 4'(nlen) + 4'(ntail);
   end

   // Classify the request and build its byte run
   always_comb begin
      packet_ident_in = packet_ident_ff;
      phase_in        = phase_ff;
      kind_in         = kind_ff;
      held_qos_in     = held_qos_ff;
      held_ident_in   = held_ident_ff;
      topic_left_in   = topic_left_ff;
      payload_left_in = payload_left_ff;
      job_valid       = 1'b0;
      job             = '0;
      idx             = 3'd0;
      if (in_fire) begin
         if (in_mode != mqttf_pkg::MODE_CONTENT) begin
            phase_in  = mqttf_pkg::PHASE_IDLE;
            job_valid = 1'b1;
            if (in_topic_length == 16'd0) begin
               job.status = mqttf_pkg::STATUS_EMPTY_TOPIC;
            end else if (too_long) begin
               job.status = mqttf_pkg::STATUS_TOO_LONG;
            end else begin
               kind_in       = in_mode;
               held_qos_in   = in_qos;
               topic_left_in = in_topic_length;
               payload_left_in = (in_mode == mqttf_pkg::MODE_PUBLISH) ?
                                 in_payload_length : 28'd0;
               held_ident_in = take_ident ? packet_ident_ff : 16'd0;
               if (take_ident) begin
                  packet_ident_in = ident_next;
               end
               phase_in     = mqttf_pkg::PHASE_TOPIC;
               job.last_idx = last_sum[2:0];
               for (int i = 0; i < mqttf_pkg::RUN_BYTES; i++) begin
                  idx = 3'(i);
                  if (idx == 3'd0) begin
                     job.data[i] = hdr;
                  end else if (idx <= nlen) begin
                     job.data[i] = len_byte[2'(idx - 3'd1)];
                  end else begin
                     job.data[i] = tail_byte[2'(idx - 3'd1 - nlen)];
                  end
               end
            end
         end else begin
            case (phase_ff)
               mqttf_pkg::PHASE_TOPIC: begin
                  job_valid     = 1'b1;
                  job.data[0]   = in_data_byte;
                  topic_left_in = topic_left_ff - 16'd1;
                  if (topic_left_in == 16'd0) begin
                     case (kind_ff)
                        mqttf_pkg::MODE_PUBLISH: begin
                           job.pend = (payload_left_ff == 28'd0);
                           if (held_qos_ff != 2'd0) begin
                              job.data[1]  = held_ident_ff[15:8];
                              job.data[2]  = held_ident_ff[7:0];
                              job.last_idx = 3'd2;
                           end
                           phase_in = (payload_left_ff == 28'd0) ?
                                      mqttf_pkg::PHASE_IDLE : mqttf_pkg::PHASE_PAYLOAD;
                        end
                        mqttf_pkg::MODE_SUBSCRIBE: begin
                           job.data[1]  = {6'd0, held_qos_ff};
                           job.last_idx = 3'd1;
                           job.pend     = 1'b1;
                           phase_in     = mqttf_pkg::PHASE_IDLE;
                        end
                        default: begin
                           job.pend = 1'b1;
                           phase_in = mqttf_pkg::PHASE_IDLE;
                        end
                     endcase
                  end
               end
               mqttf_pkg::PHASE_PAYLOAD: begin
                  job_valid       = 1'b1;
                  job.data[0]     = in_data_byte;
                  payload_left_in = payload_left_ff - 28'd1;
                  job.pend        = (payload_left_in == 28'd0);
                  if (payload_left_in == 28'd0) begin
                     phase_in = mqttf_pkg::PHASE_IDLE;
                  end
               end
               default: begin
                  job_valid = 1'b0;
               end
            endcase
         end
      end
   end

   // Hold the packet state
   always_ff @(posedge clock) begin
      if (reset) begin
         packet_ident_ff <= 16'd1;
         phase_ff        <= mqttf_pkg::PHASE_IDLE;
         kind_ff         <= mqttf_pkg::MODE_PUBLISH;
         held_qos_ff     <= 2'd0;
         held_ident_ff   <= 16'd0;
         topic_left_ff   <= 16'd0;
         payload_left_ff <= 28'd0;
      end else begin
         packet_ident_ff <= packet_ident_in;
         phase_ff        <= phase_in;
         kind_ff         <= kind_in;
         held_qos_ff     <= held_qos_in;
         held_ident_ff   <= held_ident_in;
         topic_left_ff   <= topic_left_in;
         payload_left_ff <= payload_left_in;
      end
   end

endmodule

### design/mqttf_queue.sv
// Queue: short FIFO of byte runs between the front and back ends
module mqttf_queue #(
   parameter int DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  mqttf_pkg::job_type push_job,
   input  logic               pop,
   output logic               full,
   output logic               head_valid,
   output mqttf_pkg::job_type head_job
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   mqttf_pkg::job_type        slot_ff [DEPTH];
   logic [PTR_W-1:0]          wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]          rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]          count_ff, count_in;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = slot_ff[rd_ptr_ff];

   // Advance pointers and the fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the pushed run
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

### design/mqttf_back.sv
// Back end: serializes byte runs into the registered response channel
module mqttf_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  mqttf_pkg::job_type head_job,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [7:0]         rsp_out_byte,
   output logic               rsp_packet_end,
   output logic               rsp_run_end,
   output logic [1:0]         rsp_status
);

   logic       rsp_valid_ff;
   logic [2:0] idx_ff;
   logic [7:0] byte_ff;
   logic       pend_ff;
   logic       run_end_ff;
   logic [1:0] status_ff;
   logic       load;
   logic       last;

   // Load the next byte when the output register is free
   assign load = head_valid && (!rsp_valid_ff || rsp_ready);
   assign last = (idx_ff == head_job.last_idx);
   assign pop  = load && last;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff       <= 3'd0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
         idx_ff       <= last ? 3'd0 : idx_ff + 3'd1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff    <= head_job.data[idx_ff];
         pend_ff    <= last && head_job.pend;
         run_end_ff <= last;
         status_ff  <= head_job.status;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_byte   = byte_ff;
   assign rsp_packet_end = pend_ff;
   assign rsp_run_end    = run_end_ff;
   assign rsp_status     = status_ff;

endmodule
